// ===== rtl/core/ysbc_pkg.sv =====
// Shared types, constants and helper function of the yaw stability brake controller.
package ysbc_pkg;

	// Field and divider widths.
	localparam int SPD_W        = 16;
	localparam int DIVD_W       = 32;
	localparam int DIVS_W       = 16;
	localparam int DIV_BITS_CYC = 2;
	localparam int DIV_STEPS    = DIVD_W / DIV_BITS_CYC;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
	localparam int ADDR_W       = 3;

	// Control constants.
	localparam logic [9:0]        YAW_LIMIT     = 10'd1000;
	localparam logic signed [10:0] TGT_MAX      = 11'sd1000;
	localparam logic signed [10:0] TGT_MIN      = -11'sd1000;
	localparam logic [16:0]       YAW_ERR_LIMIT = 17'd50;
	localparam logic [15:0]       LAT_LIMIT     = 16'd800;
	localparam logic [DIVD_W-1:0] SLIP_LIMIT    = 32'd25;
	localparam logic [DIVD_W-1:0] DEMAND_MAX_W  = 32'd100;
	localparam logic [6:0]        DEMAND_MAX    = 7'd100;
	localparam logic [DIVD_W-1:0] TGT_LIMIT_W   = 32'd1000;
	localparam logic [SPD_W-1:0]  MIN_SPEED     = 16'd5;
	localparam logic [6:0]        SHARE_FRONT   = 7'd70;
	localparam logic [6:0]        SHARE_REAR    = 7'd30;
	localparam logic [DIVS_W-1:0] PCT_DIVISOR   = 16'd100;
	localparam logic [DIVS_W-1:0] LAT_DIVISOR   = 16'd10;
	localparam logic [6:0]        SLIP_SCALE    = 7'd100;
	localparam logic [4:0]        TORQUE_CUT    = 5'd30;
	localparam logic [7:0]        SENS_RESET    = 8'd90;

	// Reciprocal of 100 for small values: exact for n below 43000.
	localparam logic [12:0] REC100_MUL = 13'd5243;
	localparam int          REC100_SH  = 19;

	// Register indexes, decoded from paddr[2].
	localparam logic REG_CTRL_DIS = 1'b0;
	localparam logic REG_SENS     = 1'b1;

	// Control mode of the vehicle stability function.
	typedef enum logic [1:0] {
		MODE_INACTIVE    = 2'd0,
		MODE_ACTIVE      = 2'd1,
		MODE_INTERVENING = 2'd2
	} mode_t;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_LAT_MUL,
		OP_LAT_GO,
		OP_LAT_WB,
		OP_DEM_GO,
		OP_DEM_MUL,
		OP_DEM_DIV_GO,
		OP_DEM_WB,
		OP_TGT_MUL,
		OP_TGT_GO,
		OP_TGT_WB,
		OP_CHECK,
		OP_SLIP_L_GO,
		OP_SLIP_L_WB,
		OP_SLIP_R_GO,
		OP_SLIP_R_WB,
		OP_OUT
	} op_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		C_IDLE,
		C_LAT_MUL,
		C_LAT_GO,
		C_LAT_WAIT,
		C_DEM_GO,
		C_DEM_WAIT,
		C_DEM_DIV_GO,
		C_DEM_DIV_WAIT,
		C_TGT_MUL,
		C_TGT_GO,
		C_TGT_WAIT,
		C_CHECK,
		C_SLIP_L_GO,
		C_SLIP_L_WAIT,
		C_SLIP_R_GO,
		C_SLIP_R_WAIT,
		C_OUT
	} ctrl_state_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic intervening;
		logic slow;
		logic speed_lt_min;
	} dp_sts_t;

	typedef struct packed {
		logic       dis_we;
		logic       sens_we;
		logic       dis;
		logic [7:0] sens;
	} cfg_wr_t;

	typedef struct packed {
		logic       dis;
		logic [7:0] sens;
	} cfg_rd_t;

	// Share of the brake demand in percent, truncated: d * share / 100.
	function automatic logic [6:0] share_pct(input logic [6:0] d, input logic [6:0] share);
		logic [13:0] n;
		logic [26:0] p;
		n = 14'(d) * 14'(share);
		p = 27'(n) * 27'(REC100_MUL);
		return 7'(p >> REC100_SH);
	endfunction

endpackage

// ===== rtl/core/yaw_stability_brake_controller.sv =====
// Top level of the yaw stability brake controller: register port and block wiring.
//
// One input word is one fast control tick; it always yields exactly one result word.
// Its steps run on the shared divider, which delivers two quotient bits per cycle:
// one division for lateral acceleration, two for the brake demand when braking is
// applied, and on a slow step one for the target yaw and two for the rear slip ratios.
// Slip is skipped below speed 5. A new word is accepted as soon as the sequencer is
// back in idle, while the previous result may still wait in the output register.
// Registers: control_disabled at byte address 0, stability_sensitivity at byte
// address 4; write them only while idle.
module yaw_stability_brake_controller
	import ysbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [SPD_W-1:0]   front_left_speed,
	input  logic [SPD_W-1:0]   front_right_speed,
	input  logic [SPD_W-1:0]   rear_left_speed,
	input  logic [SPD_W-1:0]   rear_right_speed,
	input  logic signed [15:0] steering_angle,
	input  logic signed [15:0] yaw_rate,
	input  logic               slow_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         brake_front,
	output logic [4:0]         brake_rear,
	output logic [6:0]         brake_left,
	output logic [6:0]         brake_right,
	output logic [4:0]         torque_cut,
	output logic               stability_active,
	output logic               traction_active,
	output logic [1:0]         control_state,
	output logic [SPD_W-1:0]   vehicle_speed,
	output logic signed [15:0] lateral_accel_out
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	cfg_wr_t cfg_wr;
	cfg_rd_t cfg_rd;
	logic    wr_en;
	logic    reg_sel;

	// Register port: the byte offset within a register is ignored.
	assign pready         = 1'b1;
	assign reg_sel        = paddr[2];
	assign wr_en          = psel && penable && pwrite && pready;
	assign cfg_wr.dis_we  = wr_en && (reg_sel == REG_CTRL_DIS);
	assign cfg_wr.sens_we = wr_en && (reg_sel == REG_SENS);
	assign cfg_wr.dis     = pwdata[0];
	assign cfg_wr.sens    = pwdata[7:0];

	// Readback multiplexer.
	always_comb begin
		unique case (reg_sel)
			REG_CTRL_DIS: prdata = {31'b0, cfg_rd.dis};
			REG_SENS:     prdata = {24'b0, cfg_rd.sens};
			default:      prdata = '0;
		endcase
	end

	ysbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ysbc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_wr            (cfg_wr),
		.cfg_rd            (cfg_rd),
		.front_left_speed  (front_left_speed),
		.front_right_speed (front_right_speed),
		.rear_left_speed   (rear_left_speed),
		.rear_right_speed  (rear_right_speed),
		.steering_angle    (steering_angle),
		.yaw_rate          (yaw_rate),
		.slow_step         (slow_step),
		.brake_front       (brake_front),
		.brake_rear        (brake_rear),
		.brake_left        (brake_left),
		.brake_right       (brake_right),
		.torque_cut        (torque_cut),
		.stability_active  (stability_active),
		.traction_active   (traction_active),
		.control_state     (control_state),
		.vehicle_speed     (vehicle_speed),
		.lateral_accel_out (lateral_accel_out)
	);

endmodule

// ===== rtl/core/ysbc_div.sv =====
// Shared restoring divider, two quotient bits per cycle.
module ysbc_div
	import ysbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic [DIVD_W-1:0] quotient,
	output logic              done
);

	logic [DIVD_W-1:0]    q_q;
	logic [DIVS_W:0]      r_q;
	logic [DIVS_W-1:0]    d_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIVD_W-1:0]    q_nxt;
	logic [DIVS_W:0]      r_nxt;

	// Two shift-and-subtract steps per cycle.
	always_comb begin
		q_nxt = q_q;
		r_nxt = r_q;
		for (int i = 0; i < DIV_BITS_CYC; i++) begin
			r_nxt = {r_nxt[DIVS_W-1:0], q_nxt[DIVD_W-1]};
			q_nxt = {q_nxt[DIVD_W-2:0], 1'b0};
			if (r_nxt >= {1'b0, d_q}) begin
				r_nxt    = r_nxt - {1'b0, d_q};
				q_nxt[0] = 1'b1;
			end
		end
	end

	// Iteration counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			q_q <= q_nxt;
			r_q <= r_nxt;
		end
	end

	assign quotient = q_q;
	assign done     = done_q;

endmodule

// ===== rtl/core/ysbc_dp.sv =====
// Datapath: input capture, multiplies, divider, control state and result registers.
module ysbc_dp
	import ysbc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_sts_t                 sts,
	input  cfg_wr_t                 cfg_wr,
	output cfg_rd_t                 cfg_rd,
	input  logic [SPD_W-1:0]        front_left_speed,
	input  logic [SPD_W-1:0]        front_right_speed,
	input  logic [SPD_W-1:0]        rear_left_speed,
	input  logic [SPD_W-1:0]        rear_right_speed,
	input  logic signed [15:0]      steering_angle,
	input  logic signed [15:0]      yaw_rate,
	input  logic                    slow_step,
	output logic [6:0]              brake_front,
	output logic [4:0]              brake_rear,
	output logic [6:0]              brake_left,
	output logic [6:0]              brake_right,
	output logic [4:0]              torque_cut,
	output logic                    stability_active,
	output logic                    traction_active,
	output logic [1:0]              control_state,
	output logic [SPD_W-1:0]        vehicle_speed,
	output logic signed [15:0]      lateral_accel_out
);

	// Captured word.
	logic signed [15:0] yaw_q, steer_q;
	logic [SPD_W-1:0]   rl_q, rr_q, speed_q;
	logic               slow_q;

	// Working registers.
	logic [DIVD_W-1:0]  mag_q;
	logic               neg_q;
	logic signed [16:0] err_q;
	logic               hit_l_q;

	// Architectural state.
	logic signed [15:0] lat_q;
	logic signed [10:0] target_q;
	mode_t              mode_q;
	logic [15:0]        cnt_q;
	logic               traction_q;
	logic               dis_q;
	logic [7:0]         sens_q;

	// Fast-part results.
	logic [6:0] bf_q, bl_q, brt_q;
	logic [4:0] br_q, tc_q;
	logic       act_q;

	// Output register.
	logic [6:0]         o_bf_q, o_bl_q, o_brt_q;
	logic [4:0]         o_br_q, o_tc_q;
	logic               o_act_q, o_trac_q;
	logic [1:0]         o_state_q;
	logic [SPD_W-1:0]   o_speed_q;
	logic signed [15:0] o_lat_q;

	// Divider connection.
	logic              div_start;
	logic [DIVD_W-1:0] div_dividend, div_quot;
	logic [DIVS_W-1:0] div_divisor;
	logic              div_done;

	// Combinational helpers.
	logic [SPD_W:0]     speed_sum;
	logic signed [32:0] mul_a_prod;
	logic signed [15:0] mul_a_op;
	logic signed [32:0] mul_a_neg;
	logic signed [16:0] lat_ext, lat_neg;
	logic [15:0]        lat_abs;
	logic signed [16:0] err_new, err_new_neg;
	logic [15:0]        err_abs;
	logic signed [16:0] chk_err, chk_err_neg;
	logic [16:0]        chk_err_abs;
	logic [17:0]        dem_sum;
	logic [6:0]         dem;
	logic [9:0]         tgt_mag;
	logic signed [10:0] tgt_pos, tgt_signed;
	logic signed [16:0] slip_l_diff, slip_r_diff, slip_l_dneg, slip_r_dneg;
	logic [15:0]        slip_l_abs, slip_r_abs;
	logic [22:0]        slip_l_num, slip_r_num;
	logic [15:0]        lat_quot_lo;
	logic [15:0]        cnt_dec;
	logic               unstable;

	ysbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	// Speed, shared multiplier operand and magnitudes.
	always_comb begin
		speed_sum   = {1'b0, front_left_speed} + {1'b0, front_right_speed};
		mul_a_op    = (cmd.op == OP_TGT_MUL) ? steer_q : yaw_q;
		mul_a_prod  = 33'(mul_a_op) * $signed({17'b0, speed_q});
		mul_a_neg   = -mul_a_prod;
		lat_ext     = 17'(lat_q);
		lat_neg     = -lat_ext;
		lat_abs     = lat_q[15] ? lat_neg[15:0] : lat_ext[15:0];
		err_new     = 17'(yaw_q) - 17'(target_q);
		err_new_neg = -err_new;
		err_abs     = err_q[16] ? 16'(-err_q) : err_q[15:0];
		chk_err     = 17'(yaw_q) - 17'(target_q);
		chk_err_neg = -chk_err;
		chk_err_abs = chk_err[16] ? chk_err_neg : chk_err;
		dem_sum     = {1'b0, err_abs, 1'b0} + 18'(div_quot[11:0]);
		dem         = (div_quot > DEMAND_MAX_W) ? DEMAND_MAX : div_quot[6:0];
		tgt_mag     = (div_quot > TGT_LIMIT_W) ? YAW_LIMIT : div_quot[9:0];
		tgt_pos     = $signed({1'b0, tgt_mag});
		tgt_signed  = neg_q ? -tgt_pos : tgt_pos;
		lat_quot_lo = neg_q ? 16'(-div_quot[15:0]) : div_quot[15:0];
		slip_l_diff = $signed({1'b0, rl_q}) - $signed({1'b0, speed_q});
		slip_r_diff = $signed({1'b0, rr_q}) - $signed({1'b0, speed_q});
		slip_l_dneg = -slip_l_diff;
		slip_r_dneg = -slip_r_diff;
		slip_l_abs  = slip_l_diff[16] ? slip_l_dneg[15:0] : slip_l_diff[15:0];
		slip_r_abs  = slip_r_diff[16] ? slip_r_dneg[15:0] : slip_r_diff[15:0];
		slip_l_num  = 23'(slip_l_abs) * 23'(SLIP_SCALE);
		slip_r_num  = 23'(slip_r_abs) * 23'(SLIP_SCALE);
		cnt_dec     = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
		unstable    = (chk_err_abs > YAW_ERR_LIMIT) || (lat_abs > LAT_LIMIT);
	end

	// Divider operand selection.
	always_comb begin
		div_start    = 1'b1;
		div_dividend = mag_q;
		div_divisor  = PCT_DIVISOR;
		case (cmd.op)
			OP_LAT_GO, OP_DEM_DIV_GO, OP_TGT_GO: begin
				div_dividend = mag_q;
				div_divisor  = PCT_DIVISOR;
			end
			OP_DEM_GO: begin
				div_dividend = DIVD_W'(lat_abs);
				div_divisor  = LAT_DIVISOR;
			end
			OP_SLIP_L_GO: begin
				div_dividend = DIVD_W'(slip_l_num);
				div_divisor  = speed_q;
			end
			OP_SLIP_R_GO: begin
				div_dividend = DIVD_W'(slip_r_num);
				div_divisor  = speed_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Captured word and working registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				yaw_q   <= yaw_rate;
				steer_q <= steering_angle;
				rl_q    <= rear_left_speed;
				rr_q    <= rear_right_speed;
				slow_q  <= slow_step;
				speed_q <= speed_sum[SPD_W:1];
			end
			OP_LAT_MUL, OP_TGT_MUL: begin
				neg_q <= mul_a_prod[32];
				mag_q <= mul_a_prod[32] ? mul_a_neg[31:0] : mul_a_prod[31:0];
			end
			OP_DEM_GO: begin
				err_q <= err_new;
			end
			OP_DEM_MUL: begin
				mag_q <= DIVD_W'(dem_sum * 26'(sens_q));
			end
			OP_SLIP_L_WB: begin
				hit_l_q <= div_quot > SLIP_LIMIT;
			end
			default: begin
			end
		endcase
	end

	// Control state, registers and fast-part results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q      <= '0;
			target_q   <= '0;
			mode_q     <= MODE_ACTIVE;
			cnt_q      <= '0;
			traction_q <= 1'b0;
			dis_q      <= 1'b0;
			sens_q     <= SENS_RESET;
			bf_q       <= '0;
			br_q       <= '0;
			bl_q       <= '0;
			brt_q      <= '0;
			tc_q       <= '0;
			act_q      <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					bf_q  <= '0;
					br_q  <= '0;
					bl_q  <= '0;
					brt_q <= '0;
					tc_q  <= '0;
					act_q <= 1'b0;
				end
				OP_LAT_WB: begin
					if (speed_q != '0) begin
						lat_q <= lat_quot_lo;
					end
				end
				OP_DEM_WB: begin
					bf_q  <= share_pct(dem, SHARE_FRONT);
					br_q  <= 5'(share_pct(dem, SHARE_REAR));
					tc_q  <= traction_q ? TORQUE_CUT : 5'd0;
					act_q <= 1'b1;
					if (!err_q[16] && err_q != '0) begin
						brt_q <= dem;
					end else begin
						bl_q <= dem;
					end
				end
				OP_TGT_WB: begin
					target_q <= (speed_q > MIN_SPEED) ? tgt_signed : 11'sd0;
				end
				OP_CHECK: begin
					if (!dis_q) begin
						if (unstable) begin
							mode_q <= MODE_INTERVENING;
							if (cnt_q != 16'hFFFF) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end else if (mode_q == MODE_INTERVENING) begin
							cnt_q <= cnt_dec;
							if (cnt_dec == '0) begin
								mode_q <= MODE_ACTIVE;
							end
						end
					end
					if (speed_q < MIN_SPEED) begin
						traction_q <= 1'b0;
					end
				end
				OP_SLIP_R_WB: begin
					traction_q <= hit_l_q || (div_quot > SLIP_LIMIT);
				end
				default: begin
				end
			endcase
			// Register writes must arrive only while the sequencer is idle; the user ensures it, not the block.
			if (cfg_wr.dis_we) begin
				dis_q <= cfg_wr.dis;
				if (cfg_wr.dis) begin
					mode_q <= MODE_INACTIVE;
				end else if (mode_q == MODE_INACTIVE) begin
					mode_q <= MODE_ACTIVE;
				end
			end
			if (cfg_wr.sens_we) begin
				sens_q <= cfg_wr.sens;
			end
		end
	end

	// Output register, loaded once the step is complete.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			o_bf_q    <= bf_q;
			o_br_q    <= br_q;
			o_bl_q    <= bl_q;
			o_brt_q   <= brt_q;
			o_tc_q    <= tc_q;
			o_act_q   <= act_q;
			o_trac_q  <= traction_q;
			o_state_q <= mode_q;
			o_speed_q <= speed_q;
			o_lat_q   <= lat_q;
		end
	end

	// Status towards the controller and register readback.
	assign sts.div_done     = div_done;
	assign sts.intervening  = (mode_q == MODE_INTERVENING);
	assign sts.slow         = slow_q;
	assign sts.speed_lt_min = (speed_q < MIN_SPEED);
	assign cfg_rd.dis       = dis_q;
	assign cfg_rd.sens      = sens_q;

	assign brake_front       = o_bf_q;
	assign brake_rear        = o_br_q;
	assign brake_left        = o_bl_q;
	assign brake_right       = o_brt_q;
	assign torque_cut        = o_tc_q;
	assign stability_active  = o_act_q;
	assign traction_active   = o_trac_q;
	assign control_state     = o_state_q;
	assign vehicle_speed     = o_speed_q;
	assign lateral_accel_out = o_lat_q;

	// Intervention always has at least one counted unstable check behind it.
	a_intervene_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_INTERVENING |-> cnt_q != '0)
		else $error("intervening with a zero intervention count");

	// The target yaw stays inside its clamp.
	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		target_q <= TGT_MAX && target_q >= TGT_MIN)
		else $error("target yaw outside its limit");

	// Braking goes to one side only.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> (bl_q == '0 || brt_q == '0))
		else $error("brake demand on both sides");

endmodule

// ===== rtl/core/ysbc_ctrl.sv =====
// Sequencer: steps the datapath through the fast and slow parts of one word.
module ysbc_ctrl
	import ysbc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath command.
	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		unique case (state_q)
			C_IDLE: begin
				if (in_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = C_LAT_MUL;
				end
			end
			C_LAT_MUL: begin
				cmd.op    = OP_LAT_MUL;
				state_nxt = C_LAT_GO;
			end
			C_LAT_GO: begin
				cmd.op    = OP_LAT_GO;
				state_nxt = C_LAT_WAIT;
			end
			C_LAT_WAIT: begin
				if (sts.div_done) begin
					cmd.op = OP_LAT_WB;
					if (sts.intervening) begin
						state_nxt = C_DEM_GO;
					end else if (sts.slow) begin
						state_nxt = C_TGT_MUL;
					end else begin
						state_nxt = C_OUT;
					end
				end
			end
			C_DEM_GO: begin
				cmd.op    = OP_DEM_GO;
				state_nxt = C_DEM_WAIT;
			end
			C_DEM_WAIT: begin
				if (sts.div_done) begin
					cmd.op    = OP_DEM_MUL;
					state_nxt = C_DEM_DIV_GO;
				end
			end
			C_DEM_DIV_GO: begin
				cmd.op    = OP_DEM_DIV_GO;
				state_nxt = C_DEM_DIV_WAIT;
			end
			C_DEM_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.op    = OP_DEM_WB;
					state_nxt = sts.slow ? C_TGT_MUL : C_OUT;
				end
			end
			C_TGT_MUL: begin
				cmd.op    = OP_TGT_MUL;
				state_nxt = C_TGT_GO;
			end
			C_TGT_GO: begin
				cmd.op    = OP_TGT_GO;
				state_nxt = C_TGT_WAIT;
			end
			C_TGT_WAIT: begin
				if (sts.div_done) begin
					cmd.op    = OP_TGT_WB;
					state_nxt = C_CHECK;
				end
			end
			C_CHECK: begin
				cmd.op    = OP_CHECK;
				state_nxt = sts.speed_lt_min ? C_OUT : C_SLIP_L_GO;
			end
			C_SLIP_L_GO: begin
				cmd.op    = OP_SLIP_L_GO;
				state_nxt = C_SLIP_L_WAIT;
			end
			C_SLIP_L_WAIT: begin
				if (sts.div_done) begin
					cmd.op    = OP_SLIP_L_WB;
					state_nxt = C_SLIP_R_GO;
				end
			end
			C_SLIP_R_GO: begin
				cmd.op    = OP_SLIP_R_GO;
				state_nxt = C_SLIP_R_WAIT;
			end
			C_SLIP_R_WAIT: begin
				if (sts.div_done) begin
					cmd.op    = OP_SLIP_R_WB;
					state_nxt = C_OUT;
				end
			end
			C_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op    = OP_OUT;
					state_nxt = C_IDLE;
				end
			end
			default: begin
				state_nxt = C_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != C_IDLE);
	assign out_valid = out_valid_q;

	// A divider result only ever arrives while a wait state expects it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == C_LAT_WAIT || state_q == C_DEM_WAIT ||
			state_q == C_DEM_DIV_WAIT || state_q == C_TGT_WAIT ||
			state_q == C_SLIP_L_WAIT || state_q == C_SLIP_R_WAIT))
		else $error("divider result outside a wait state");

	// An accepted word starts the lateral acceleration multiply.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == C_LAT_MUL)
		else $error("accepted word did not start a step");

	// Loading the output register always raises the output valid.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |=> out_valid_q)
		else $error("result loaded without output valid");

endmodule

// ===== test/yaw_stability_brake_controller_tb.sv =====
// Self-checking testbench for the yaw stability brake controller.
`timescale 1ns / 1ps

module yaw_stability_brake_controller_tb;
	import ysbc_pkg::*;

	// Control limits used by the prediction.
	localparam int YAW_CLAMP    = 1000;
	localparam int ERR_THRESH   = 50;
	localparam int LAT_THRESH   = 800;
	localparam int SLIP_THRESH  = 25;
	localparam int SLIP_CLAMP   = 100;
	localparam int DEMAND_CAP   = 100;
	localparam int LOW_SPEED    = 5;
	localparam int FRONT_PCT    = 70;
	localparam int REAR_PCT     = 30;
	localparam int TORQUE_PCT   = 30;
	localparam int COUNT_MAX    = 65535;

	// Register addresses and run shape.
	localparam logic [ADDR_W-1:0] ADDR_DIS  = {REG_CTRL_DIS, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_SENS = {REG_SENS, 2'b00};
	localparam int CHUNKS       = 4;
	localparam int CHUNK_WORDS  = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int CFG_GAP      = 8;
	localparam int DRAIN_CYCLES = 120;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		logic [15:0]        fl;
		logic [15:0]        fr;
		logic [15:0]        rl;
		logic [15:0]        rr;
		logic signed [15:0] steer;
		logic signed [15:0] yaw;
		logic               slow;
	} tick_t;

	typedef struct {
		logic [6:0]         brake_front;
		logic [4:0]         brake_rear;
		logic [6:0]         brake_left;
		logic [6:0]         brake_right;
		logic [4:0]         torque_cut;
		logic               stab;
		logic               trac;
		mode_t              state;
		logic [15:0]        speed;
		logic signed [15:0] lat;
	} brake_res_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [SPD_W-1:0]   front_left_speed = '0;
	logic [SPD_W-1:0]   front_right_speed = '0;
	logic [SPD_W-1:0]   rear_left_speed = '0;
	logic [SPD_W-1:0]   rear_right_speed = '0;
	logic signed [15:0] steering_angle = '0;
	logic signed [15:0] yaw_rate = '0;
	logic               slow_step = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [6:0]         brake_front;
	logic [4:0]         brake_rear;
	logic [6:0]         brake_left;
	logic [6:0]         brake_right;
	logic [4:0]         torque_cut;
	logic               stability_active;
	logic               traction_active;
	logic [1:0]         control_state;
	logic [SPD_W-1:0]   vehicle_speed;
	logic signed [15:0] lateral_accel_out;

	// Predicted controller state and register copies.
	mode_t              mode_q;
	int                 count_q;
	int                 tgt_q;
	logic signed [15:0] lat_q;
	logic               trac_q;
	logic               dis_q;
	int                 sens_q;

	brake_res_t pending_results[$];
	brake_res_t head_res;
	logic       hold_off = 1'b0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         mismatches = 0;
	int         results_seen = 0;
	int         ticks_sent = 0;
	int         reg_writes = 0;

	yaw_stability_brake_controller dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.front_left_speed  (front_left_speed),
		.front_right_speed (front_right_speed),
		.rear_left_speed   (rear_left_speed),
		.rear_right_speed  (rear_right_speed),
		.steering_angle    (steering_angle),
		.yaw_rate          (yaw_rate),
		.slow_step         (slow_step),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.brake_front       (brake_front),
		.brake_rear        (brake_rear),
		.brake_left        (brake_left),
		.brake_right       (brake_right),
		.torque_cut        (torque_cut),
		.stability_active  (stability_active),
		.traction_active   (traction_active),
		.control_state     (control_state),
		.vehicle_speed     (vehicle_speed),
		.lateral_accel_out (lateral_accel_out)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Absolute value at full width.
	function automatic longint abs_l(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Signed random value in [lo, hi].
	function automatic int rand_in(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// True when a rear wheel slips by more than the threshold, in percent of speed.
	function automatic bit slip_over(input logic [15:0] wheel, input longint speed);
		longint s;
		s = ((longint'(wheel) - speed) * 100) / speed;
		if (s > SLIP_CLAMP)
			s = SLIP_CLAMP;
		if (s < -SLIP_CLAMP)
			s = -SLIP_CLAMP;
		return abs_l(s) > SLIP_THRESH;
	endfunction

	function automatic tick_t mk_tick(input int fl, input int fr, input int rl, input int rr,
		input int steer, input int yaw, input bit slow);
		tick_t t;
		t.fl    = 16'(fl);
		t.fr    = 16'(fr);
		t.rl    = 16'(rl);
		t.rr    = 16'(rr);
		t.steer = 16'(steer);
		t.yaw   = 16'(yaw);
		t.slow  = slow;
		return t;
	endfunction

	task automatic reset_model();
		mode_q  = MODE_ACTIVE;
		count_q = 0;
		tgt_q   = 0;
		lat_q   = '0;
		trac_q  = 1'b0;
		dis_q   = 1'b0;
		sens_q  = 90;
	endtask

	// Computes the result word of one tick and advances the predicted state.
	function automatic brake_res_t predict_brake_word(input tick_t t);
		brake_res_t r;
		longint speed;
		longint yaw;
		longint steer;
		longint err;
		longint d;
		longint tg;
		speed = (longint'(t.fl) + longint'(t.fr)) / 2;
		yaw = t.yaw;
		steer = t.steer;
		r.brake_front = '0;
		r.brake_rear  = '0;
		r.brake_left  = '0;
		r.brake_right = '0;
		r.torque_cut  = '0;
		r.stab        = 1'b0;

		// Fast part: lateral acceleration is held while the car stands still.
		if (speed > 0)
			lat_q = 16'((yaw * speed) / 100);
		if (mode_q == MODE_INTERVENING) begin
			err = yaw - longint'(tgt_q);
			d = abs_l(err) * 2 + abs_l(longint'(lat_q)) / 10;
			d = (d * longint'(sens_q)) / 100;
			if (d > DEMAND_CAP)
				d = DEMAND_CAP;
			if (err > 0)
				r.brake_right = 7'(d);
			else
				r.brake_left = 7'(d);
			r.brake_front = 7'((d * FRONT_PCT) / 100);
			r.brake_rear  = 5'((d * REAR_PCT) / 100);
			r.torque_cut  = trac_q ? 5'(TORQUE_PCT) : 5'd0;
			r.stab        = 1'b1;
		end

		// Slow part: target yaw, stability check with hysteresis, rear slip.
		if (t.slow) begin
			if (speed > LOW_SPEED) begin
				tg = (steer * speed) / 100;
				if (tg > YAW_CLAMP)
					tg = YAW_CLAMP;
				if (tg < -YAW_CLAMP)
					tg = -YAW_CLAMP;
				tgt_q = int'(tg);
			end else begin
				tgt_q = 0;
			end
			err = yaw - longint'(tgt_q);
			if (!dis_q) begin
				if (abs_l(err) > ERR_THRESH || abs_l(longint'(lat_q)) > LAT_THRESH) begin
					mode_q = MODE_INTERVENING;
					if (count_q < COUNT_MAX)
						count_q++;
				end else if (mode_q == MODE_INTERVENING) begin
					if (count_q > 0)
						count_q--;
					if (count_q == 0)
						mode_q = MODE_ACTIVE;
				end
			end
			if (speed < LOW_SPEED)
				trac_q = 1'b0;
			else
				trac_q = slip_over(t.rl, speed) || slip_over(t.rr, speed);
		end

		r.trac  = trac_q;
		r.state = mode_q;
		r.speed = 16'(speed);
		r.lat   = lat_q;
		return r;
	endfunction

	// Mostly plausible driving ticks around the target yaw, with some pure noise.
	function automatic tick_t random_tick();
		tick_t t;
		int v;
		int steer;
		int tg;
		int yaw;
		int rl;
		int rr;
		if ($urandom_range(0, 9) == 0) begin
			t.fl    = 16'($urandom);
			t.fr    = 16'($urandom);
			t.rl    = 16'($urandom);
			t.rr    = 16'($urandom);
			t.steer = 16'($urandom);
			t.yaw   = 16'($urandom);
			t.slow  = 1'($urandom);
			return t;
		end
		case ($urandom_range(0, 3))
			0: begin
				v = rand_in(0, 8);
			end
			1, 2: begin
				v = rand_in(9, 2500);
			end
			default: begin
				v = rand_in(2501, 65000);
			end
		endcase
		steer = ($urandom_range(0, 3) == 0) ? rand_in(-90, 90) : rand_in(-30, 30);
		tg = (steer * v) / 100;
		if (tg > YAW_CLAMP)
			tg = YAW_CLAMP;
		if (tg < -YAW_CLAMP)
			tg = -YAW_CLAMP;
		case ($urandom_range(0, 3))
			0, 1: begin
				yaw = tg + rand_in(-50, 50);
			end
			2: begin
				yaw = tg + rand_in(-300, 300);
			end
			default: begin
				yaw = tg + rand_in(-30, 30);
			end
		endcase
		rl = v + (v * rand_in(-35, 35)) / 100;
		rr = v + (v * rand_in(-20, 20)) / 100;
		t.fl    = 16'(v);
		t.fr    = 16'((v > 65530) ? v : v + rand_in(0, 3));
		t.rl    = 16'((rl > 65535) ? 65535 : rl);
		t.rr    = 16'((rr > 65535) ? 65535 : rr);
		t.steer = 16'(steer);
		t.yaw   = 16'(yaw);
		t.slow  = ($urandom_range(0, 99) < 60);
		return t;
	endfunction

	// Offers one tick word after a random gap and records its expected result.
	task automatic send_tick(input tick_t t);
		while (int'($urandom_range(0, 99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		front_left_speed  <= t.fl;
		front_right_speed <= t.fr;
		rear_left_speed   <= t.rl;
		rear_right_speed  <= t.rr;
		steering_angle    <= t.steer;
		yaw_rate          <= t.yaw;
		slow_step         <= t.slow;
		in_valid          <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pending_results.push_back(predict_brake_word(t));
		ticks_sent++;
	endtask

	// Stops offering words and waits until every result has been taken.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (CFG_GAP) @(posedge clk);
	endtask

	// Register write: setup phase, then access phase; pready is always high.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_DIS) begin
			dis_q = data[0];
			if (dis_q)
				mode_q = MODE_INACTIVE;
			else if (mode_q == MODE_INACTIVE)
				mode_q = MODE_ACTIVE;
		end else begin
			sens_q = int'(data[7:0]);
		end
		reg_writes++;
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch in %s of result %0d: expected %0d, got %0d",
					name, results_seen, exp_v, act_v);
		end
	endtask

	// Result checker and output stall generator.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result word %0d arrived with nothing expected", results_seen);
			end else begin
				head_res = pending_results.pop_front();
				check_field("brake_front", head_res.brake_front, brake_front);
				check_field("brake_rear", head_res.brake_rear, brake_rear);
				check_field("brake_left", head_res.brake_left, brake_left);
				check_field("brake_right", head_res.brake_right, brake_right);
				check_field("torque_cut", head_res.torque_cut, torque_cut);
				check_field("stability_active", head_res.stab, stability_active);
				check_field("traction_active", head_res.trac, traction_active);
				check_field("control_state", head_res.state, control_state);
				check_field("vehicle_speed", head_res.speed, vehicle_speed);
				check_field("lateral_accel_out", head_res.lat, lateral_accel_out);
			end
		end
		out_stall <= hold_off || (int'($urandom_range(0, 99)) < recv_idle_pct);
	end

	// Zero and full-scale fields, standstill hold of lateral acceleration and wrap.
	task automatic test_reset_and_extremes();
		send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0, 0, 0, 1));
		send_tick(mk_tick(100, 100, 100, 100, 0, 500, 0));
		send_tick(mk_tick(0, 1, 65535, 65535, -32768, -3000, 0));
		send_tick(mk_tick(65535, 65535, 65535, 65535, 32767, -32768, 1));
	endtask

	// Entry into intervention, both brake sides, demand clamp and hysteresis exit.
	task automatic test_intervention();
		send_tick(mk_tick(1000, 1000, 1000, 1000, 10, 300, 1));
		send_tick(mk_tick(1000, 1000, 1000, 1000, 10, 300, 0));
		send_tick(mk_tick(1000, 1000, 1000, 1000, 10, -300, 0));
		send_tick(mk_tick(1000, 1000, 1000, 1000, 10, 100, 0));
		send_tick(mk_tick(1000, 1000, 1000, 1000, 10, 32767, 0));
		repeat (3) send_tick(mk_tick(200, 200, 200, 200, 10, 20, 1));
		send_tick(mk_tick(2000, 2000, 2000, 2000, 45, 900, 1));
		send_tick(mk_tick(201, 200, 200, 200, 10, 20, 1));
		send_tick(mk_tick(4, 7, 0, 0, 1000, 0, 1));
		send_tick(mk_tick(6, 6, 6, 6, 1000, 60, 1));
		send_tick(mk_tick(4, 4, 100, 100, 1000, 0, 1));
	endtask

	// Rear slip on either wheel, the threshold itself, and torque cut while braking.
	task automatic test_traction();
		send_tick(mk_tick(1000, 1000, 2000, 1000, 0, 500, 1));
		send_tick(mk_tick(1000, 1000, 1000, 1000, 0, 500, 0));
		send_tick(mk_tick(1000, 1000, 1250, 750, 0, 0, 1));
		send_tick(mk_tick(1000, 1000, 1260, 1000, 0, 0, 1));
		send_tick(mk_tick(1000, 1000, 1000, 740, 0, 0, 1));
	endtask

	// Disabled control skips the stability check; clearing it reactivates.
	task automatic test_disable();
		wait_idle();
		write_reg(ADDR_DIS, 32'd1);
		send_tick(mk_tick(1000, 1000, 1000, 1000, 0, 500, 1));
		send_tick(mk_tick(1000, 1000, 1000, 1000, 0, 500, 0));
		wait_idle();
		write_reg(ADDR_DIS, 32'd0);
		send_tick(mk_tick(1000, 1000, 1000, 1000, 0, 500, 1));
	endtask

	// Sensitivity at both ends of its range.
	task automatic test_sensitivity();
		wait_idle();
		write_reg(ADDR_SENS, 32'd0);
		send_tick(mk_tick(1000, 1000, 1000, 1000, 0, -500, 0));
		wait_idle();
		write_reg(ADDR_SENS, 32'd255);
		send_tick(mk_tick(1000, 1000, 1000, 1000, 0, 500, 0));
		send_tick(mk_tick(100, 100, 100, 100, 0, 10, 0));
		wait_idle();
		write_reg(ADDR_SENS, 32'd90);
	endtask

	// Random traffic in chunks, with fresh register settings between chunks.
	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		for (int c = 0; c < CHUNKS; c++) begin
			wait_idle();
			write_reg(ADDR_DIS, ($urandom_range(0, 7) == 0) ? 32'd1 : 32'd0);
			case ($urandom_range(0, 3))
				0: begin
					write_reg(ADDR_SENS, 32'd255);
				end
				1: begin
					write_reg(ADDR_SENS, 32'd90);
				end
				2: begin
					write_reg(ADDR_SENS, 32'($urandom_range(0, 255)));
				end
				default: begin
					write_reg(ADDR_SENS, 32'($urandom_range(50, 150)));
				end
			endcase
			send_idle_pct = send_pct;
			recv_idle_pct = recv_pct;
			repeat (CHUNK_WORDS) send_tick(random_tick());
		end
	endtask

	// Long output hold-off while words keep coming, so the input stalls.
	task automatic test_backpressure();
		wait_idle();
		write_reg(ADDR_DIS, 32'd0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		repeat (12) send_tick(random_tick());
	endtask

	initial begin
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 9;
		recv_idle_pct = 69;
		test_reset_and_extremes();
		test_intervention();
		test_traction();
		test_disable();
		test_sensitivity();
		test_random_traffic(9, 69);
		test_random_traffic(69, 9);
		test_random_traffic(0, 0);
		test_backpressure();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d tick words and checked %0d result words over %0d register writes,",
			ticks_sent, results_seen, reg_writes);
		$display("with three idling mixes and one long output hold-off; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("yaw_stability_brake_controller_tb: clean");
		else
			$display("yaw_stability_brake_controller_tb: errors");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("yaw_stability_brake_controller_tb: errors");
		$finish;
	end

endmodule
